FILE: rtl/core/pwic_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared constants, widths and register indexes for the windowed-integral
// PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pwic_pkg;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int SUM_WIDTH      = 24;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int WINDOW_W = 16;
  localparam int LIMIT_W  = 7;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int DERIV_W  = ERR_W + 1;
  localparam int DRIVE_W  = 8;

  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + SUM_WIDTH;
  localparam int PROD_D_W = GAIN_W + DERIV_W;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int QUOT_W   = ACC_W - GAIN_FRAC_BITS;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic signed [SAMPLE_W-1:0] SETPOINT_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0]   GAIN_P_RST   = 16'sd1638;
  localparam logic signed [GAIN_W-1:0]   GAIN_I_RST   = 16'sd0;
  localparam logic signed [GAIN_W-1:0]   GAIN_D_RST   = 16'sd4096;
  localparam logic [WINDOW_W-1:0]        WINDOW_RST   = 16'd50;
  localparam logic [LIMIT_W-1:0]         LIMIT_RST    = 7'd127;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_WINDOW   = 3'd4,
    REG_LIMIT    = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/core/pwic_if.sv
// ----------------------------------------------------------------------------
// PID controller channels
// Valid/ready channels for sensor samples and drive commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwic_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pwic_pkg::SAMPLE_W-1:0]   sample;
  logic                                   run;

  modport source (output valid, output sample, output run, input ready);
  modport sink   (input valid, input sample, input run, output ready);
endinterface

interface pwic_command_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pwic_pkg::DRIVE_W-1:0]    drive;
  logic signed [pwic_pkg::ERR_W-1:0]      error_out;
  logic                                   clamped;

  modport source (output valid, output drive, output error_out, output clamped, input ready);
  modport sink   (input valid, input drive, input error_out, input clamped, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pid_windowed_integral_controller.sv
// ----------------------------------------------------------------------------
// PID controller with integral window and output clamp
// A command transaction is offered once its sample transaction has passed the error
// and integral register, then the result register; a command-side stall can hold it.
// Throughput: one transaction per cycle; the input stalls only while both
// registers are full and the command side is not ready.
// Reset: synchronous, clears both stage valid flags, the integral and previous error and
// loads the default setpoint, gains, window and drive limit.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_windowed_integral_controller (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [pwic_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  wire logic [pwic_pkg::CFG_DATA_W-1:0]       wr_data,
  pwic_sample_if.sink                                sensor,
  pwic_command_if.source                             command
);

  localparam int SW = pwic_pkg::SUM_WIDTH;
  localparam int F  = pwic_pkg::GAIN_FRAC_BITS;

  logic signed [pwic_pkg::SAMPLE_W-1:0] setpoint;
  logic signed [pwic_pkg::GAIN_W-1:0]   gain_p;
  logic signed [pwic_pkg::GAIN_W-1:0]   gain_i;
  logic signed [pwic_pkg::GAIN_W-1:0]   gain_d;
  logic [pwic_pkg::WINDOW_W-1:0]        integral_window;
  logic [pwic_pkg::LIMIT_W-1:0]         drive_limit;

  logic signed [pwic_pkg::ERR_W-1:0]    previous_error;
  logic signed [SW-1:0]                 error_sum;
  logic signed [pwic_pkg::ERR_W-1:0]    previous_error_next;
  logic signed [SW-1:0]                 error_sum_next;

  logic                                 v1;
  logic                                 rdy1, rdy2;
  logic signed [pwic_pkg::ERR_W-1:0]    s1_err;
  logic signed [SW-1:0]                 s1_sum;
  logic signed [pwic_pkg::DERIV_W-1:0]  s1_deriv;

  logic                                 in_accept;
  logic signed [pwic_pkg::ERR_W-1:0]    err_c;
  logic [pwic_pkg::ERR_W-1:0]           mag_c;
  logic                                 integrate;
  logic signed [SW:0]                   sum_add;
  logic signed [SW-1:0]                 sum_sat;
  logic signed [pwic_pkg::DERIV_W-1:0]  deriv_c;

  logic signed [pwic_pkg::PROD_P_W-1:0] prod_p;
  logic signed [pwic_pkg::PROD_I_W-1:0] prod_i;
  logic signed [pwic_pkg::PROD_D_W-1:0] prod_d;
  logic signed [pwic_pkg::ACC_W-1:0]    acc;
  logic signed [pwic_pkg::ACC_W-1:0]    acc_biased;
  logic signed [pwic_pkg::QUOT_W-1:0]   quot;
  logic signed [pwic_pkg::QUOT_W-1:0]   lim_pos;
  logic signed [pwic_pkg::QUOT_W-1:0]   lim_neg;
  logic signed [pwic_pkg::DRIVE_W-1:0]  drive_c;
  logic                                 clamped_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint        <= pwic_pkg::SETPOINT_RST;
      gain_p          <= pwic_pkg::GAIN_P_RST;
      gain_i          <= pwic_pkg::GAIN_I_RST;
      gain_d          <= pwic_pkg::GAIN_D_RST;
      integral_window <= pwic_pkg::WINDOW_RST;
      drive_limit     <= pwic_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (pwic_pkg::cfg_reg_t'(wr_index))
        pwic_pkg::REG_SETPOINT: setpoint        <= wr_data;
        pwic_pkg::REG_GAIN_P:   gain_p          <= wr_data;
        pwic_pkg::REG_GAIN_I:   gain_i          <= wr_data;
        pwic_pkg::REG_GAIN_D:   gain_d          <= wr_data;
        pwic_pkg::REG_WINDOW:   integral_window <= wr_data;
        pwic_pkg::REG_LIMIT:    drive_limit     <= wr_data[pwic_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain.
  assign rdy2          = !command.valid || command.ready;
  assign rdy1          = !v1 || rdy2;
  assign sensor.ready  = rdy1;
  assign in_accept     = sensor.valid && rdy1;

  // Stage 1: error, windowed integral and derivative.
  always_comb begin
    err_c     = pwic_pkg::ERR_W'(sensor.sample) - pwic_pkg::ERR_W'(setpoint);
    mag_c     = err_c[pwic_pkg::ERR_W-1] ? pwic_pkg::ERR_W'(-err_c) : pwic_pkg::ERR_W'(err_c);
    integrate = (gain_i != '0) && (mag_c < {1'b0, integral_window});
    sum_add   = (SW+1)'(error_sum) + (SW+1)'(err_c);
    if (sum_add[SW] != sum_add[SW-1]) begin
      sum_sat = {sum_add[SW], {(SW-1){~sum_add[SW]}}};
    end else begin
      sum_sat = sum_add[SW-1:0];
    end
    deriv_c = pwic_pkg::DERIV_W'(err_c) - pwic_pkg::DERIV_W'(previous_error);
    if (!sensor.run) begin
      previous_error_next = '0;
      error_sum_next      = '0;
    end else begin
      previous_error_next = err_c;
      error_sum_next      = integrate ? sum_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (in_accept) begin
      previous_error <= previous_error_next;
      error_sum      <= error_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_err   <= previous_error_next;
      s1_sum   <= error_sum_next;
      s1_deriv <= sensor.run ? deriv_c : '0;
    end
  end

  // Stage 2: gain products, sum, divide with truncation toward zero, clamp.
  always_comb begin
    prod_p     = pwic_pkg::PROD_P_W'(gain_p) * pwic_pkg::PROD_P_W'(s1_err);
    prod_i     = pwic_pkg::PROD_I_W'(gain_i) * pwic_pkg::PROD_I_W'(s1_sum);
    prod_d     = pwic_pkg::PROD_D_W'(gain_d) * pwic_pkg::PROD_D_W'(s1_deriv);
    acc        = pwic_pkg::ACC_W'(prod_p) + pwic_pkg::ACC_W'(prod_i)
               + pwic_pkg::ACC_W'(prod_d);
    acc_biased = acc;
    if (acc[pwic_pkg::ACC_W-1]) begin
      acc_biased = acc + pwic_pkg::ACC_W'((1 << F) - 1);
    end
    quot    = signed'(acc_biased[pwic_pkg::ACC_W-1:F]);
    lim_pos = signed'(pwic_pkg::QUOT_W'({1'b0, drive_limit}));
    lim_neg = -lim_pos;
    priority if (quot > lim_pos) begin
      drive_c   = pwic_pkg::DRIVE_W'(lim_pos);
      clamped_c = 1'b1;
    end else if (quot < lim_neg) begin
      drive_c   = pwic_pkg::DRIVE_W'(lim_neg);
      clamped_c = 1'b1;
    end else begin
      drive_c   = pwic_pkg::DRIVE_W'(quot);
      clamped_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (rdy2) begin
      command.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      command.drive     <= drive_c;
      command.error_out <= s1_err;
      command.clamped   <= clamped_c;
    end
  end

  // A stopped transaction clears the loop history.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && !sensor.run |=> previous_error == '0 && error_sum == '0)
    else $error("history not cleared after a stopped transaction");

  // With no integral gain the integral stays cleared.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && gain_i == '0 |=> error_sum == '0)
    else $error("integral accumulated with zero integral gain");

  // An accepted transaction always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> v1)
    else $error("accepted transaction lost at the first stage");

  // A stalled first stage holds its transaction.
  assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(s1_err) && $stable(s1_sum) && $stable(s1_deriv))
    else $error("stalled first stage changed");

  // A stalled command transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    command.valid && !command.ready |=> command.valid && $stable(command.drive)
      && $stable(command.error_out) && $stable(command.clamped))
    else $error("stalled command transaction changed");

endmodule

`default_nettype wire
